// ----- hdl/assert_macros.svh -----
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property check, disabled while reset is asserted.
`define ASSERT_PROP(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
	`ASSERT_PROP(name, clk, rst_n, !(cond), msg)

`endif

// ----- hdl/lsmt_pkg.sv -----
package lsmt_pkg;

	// LCD mode codes as seen in the STAT register
	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} mode_t;

	// Last dot of OAM search and of pixel transfer on a visible line
	localparam logic [8:0] OAM_END_DOT  = 9'd79;
	localparam logic [8:0] XFER_END_DOT = 9'd251;

	// Bit positions of the STAT interrupt enables
	localparam int EN_HBLANK = 0;
	localparam int EN_VBLANK = 1;
	localparam int EN_OAM    = 2;
	localparam int EN_COINC  = 3;

	// One input beat
	typedef struct packed {
		logic [3:0] stat_enables;
		logic [7:0] compare_line;
		logic       lcd_enable;
	} in_item_t;

	// One result beat
	typedef struct packed {
		logic       frame_restart;
		logic       pixel_transfer_start;
		logic       oam_search_start;
		logic       vblank_request;
		logic       stat_request;
		logic       coincidence;
		logic [1:0] mode;
		logic [7:0] line;
	} result_t;

	// Mode, flag and STAT line tracking through the steps of one tick
	typedef struct packed {
		mode_t mode;
		logic  coinc;
		logic  prev;
		logic  stat_p;
		logic  oam_p;
		logic  xfer_p;
	} stat_trk_t;

	// Combined STAT interrupt line
	function automatic logic stat_level(logic [3:0] en, mode_t mode, logic coinc);
		return (en[EN_HBLANK] && (mode == MODE_HBLANK)) ||
		       (en[EN_VBLANK] && (mode == MODE_VBLANK)) ||
		       (en[EN_OAM]    && (mode == MODE_OAM))    ||
		       (en[EN_COINC]  && coinc);
	endfunction

	// Mode change: re-evaluate the STAT line, flag entries into OAM / transfer
	function automatic stat_trk_t apply_mode(stat_trk_t s, mode_t m, logic [3:0] en);
		stat_trk_t r;
		logic      lvl;
		r = s;
		r.mode = m;
		lvl = stat_level(en, m, r.coinc);
		if (!r.prev && lvl) begin
			r.stat_p = 1'b1;
		end
		r.prev = lvl;
		if (m != s.mode) begin
			if (m == MODE_OAM) begin
				r.oam_p = 1'b1;
			end else if (m == MODE_XFER) begin
				r.xfer_p = 1'b1;
			end
		end
		return r;
	endfunction

	// Line write: a match sets the flag and re-evaluates STAT, a miss only clears it
	function automatic stat_trk_t apply_line(stat_trk_t s, logic match, logic [3:0] en);
		stat_trk_t r;
		logic      lvl;
		r = s;
		r.coinc = match;
		if (match) begin
			lvl = stat_level(en, r.mode, 1'b1);
			if (!r.prev && lvl) begin
				r.stat_p = 1'b1;
			end
			r.prev = lvl;
		end
		return r;
	endfunction

endpackage

// ----- hdl/lcd_scanline_mode_timer.sv -----
// LCD scanline and mode timer.
// Slave channel s_axis_*: one beat per dot tick, carrying the LCD enable bit,
// the line compare value and the four STAT interrupt enables.
// Master channel m_axis_*: one beat per accepted tick with the line number,
// mode, coincidence flag and the one-beat pulses (STAT request, V-blank
// request, OAM search start, pixel transfer start, frame restart).
// A beat is registered at the input; its result is computed in one
// combinational pass and loaded into the result register.
// Throughput: one beat per cycle without a stall; the dot counter, line and
// mode update in the same cycle that the result register loads.
// Reset: timing state returns to dot 0, line 0, H-blank, STAT line low;
// both channels come up empty.
// When the receiver stalls, the result register holds its beat and the
// input register takes one more beat; after that s_axis_tready drops
// until m_axis_tready returns. No beat is lost or duplicated.
module lcd_scanline_mode_timer #(
	parameter int DOTS_PER_LINE = 456,
	parameter int VISIBLE_LINES = 144,
	parameter int LAST_LINE     = 153
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [0] lcd_enable, [8:1] compare_line, [12:9] stat_enables, [15:13] zero
	input  logic [15:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] line, [9:8] mode, [10] coincidence, [11] stat_request,
	// [12] vblank_request, [13] oam_search_start, [14] pixel_transfer_start,
	// [15] frame_restart
	output logic [15:0] m_axis_tdata
);

	lsmt_pkg::in_item_t in_item;
	lsmt_pkg::in_item_t item_s1;
	lsmt_pkg::result_t  res;
	lsmt_pkg::result_t  res_s2;
	logic               valid_s1;
	logic               valid_s2;
	logic               advance;

	// Unpack input beat
	assign in_item.lcd_enable   = s_axis_tdata[0];
	assign in_item.compare_line = s_axis_tdata[8:1];
	assign in_item.stat_enables = s_axis_tdata[12:9];

	// Move a beat into the result register when it is free or being drained
	assign advance = valid_s1 && (!valid_s2 || m_axis_tready);

	lsmt_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.take     (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	lsmt_core #(
		.DOTS_PER_LINE (DOTS_PER_LINE),
		.VISIBLE_LINES (VISIBLE_LINES),
		.LAST_LINE     (LAST_LINE)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.res     (res)
	);

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = res_s2;

endmodule

// ----- hdl/lsmt_in_stage.sv -----
module lsmt_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lsmt_pkg::in_item_t  in_item,
	input  logic                take,
	output logic                valid_s1,
	output lsmt_pkg::in_item_t  item_s1
);

	// Free slot, or the held beat moves on this cycle
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ----- hdl/lsmt_core.sv -----
`include "assert_macros.svh"

module lsmt_core #(
	parameter int DOTS_PER_LINE = 456,
	parameter int VISIBLE_LINES = 144,
	parameter int LAST_LINE     = 153
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  lsmt_pkg::in_item_t  item,
	output lsmt_pkg::result_t   res
);

	localparam logic [8:0] DotsLine = 9'(DOTS_PER_LINE);
	localparam logic [7:0] VisLine  = 8'(VISIBLE_LINES);
	localparam logic [7:0] LastLine = 8'(LAST_LINE);

	logic              [8:0] dot_q;
	logic              [7:0] line_q;
	lsmt_pkg::mode_t         mode_q;
	logic                    prev_q;
	logic                    coinc_q;

	logic              [8:0] dot_inc;
	logic              [7:0] line_inc;
	logic              [8:0] dot_n;
	logic              [7:0] line_n;
	logic                    l1_en;
	lsmt_pkg::mode_t         m1;
	logic                    m2_en;
	logic                    l2_en;
	logic              [7:0] l2_line;
	logic                    vbl_p;
	logic                    rst_p;
	lsmt_pkg::stat_trk_t     trk0;
	lsmt_pkg::stat_trk_t     trk1;
	lsmt_pkg::stat_trk_t     trk2;
	lsmt_pkg::stat_trk_t     trk3;
	lsmt_pkg::stat_trk_t     trk4;

	assign dot_inc  = dot_q + 9'd1;
	assign line_inc = line_q + 8'd1;

	// Pick the steps of this tick: line write, mode set, second mode set, line write
	always_comb begin
		dot_n   = dot_q;
		line_n  = line_q;
		l1_en   = 1'b0;
		m1      = lsmt_pkg::MODE_HBLANK;
		m2_en   = 1'b0;
		l2_en   = 1'b0;
		l2_line = 8'd0;
		vbl_p   = 1'b0;
		rst_p   = 1'b0;
		if (!item.lcd_enable) begin
			dot_n  = 9'd0;
			line_n = 8'd0;
			l2_en  = 1'b1;
		end else if (line_q < VisLine) begin
			dot_n = dot_inc;
			if (dot_inc <= lsmt_pkg::OAM_END_DOT) begin
				m1 = lsmt_pkg::MODE_OAM;
			end else if (dot_inc <= lsmt_pkg::XFER_END_DOT) begin
				m1 = lsmt_pkg::MODE_XFER;
			end else if (dot_inc < DotsLine) begin
				m1 = lsmt_pkg::MODE_HBLANK;
			end else begin
				// end of a visible line
				dot_n  = dot_inc - DotsLine;
				line_n = line_inc;
				l1_en  = 1'b1;
				if (line_inc == VisLine) begin
					m1    = lsmt_pkg::MODE_VBLANK;
					vbl_p = 1'b1;
				end else begin
					m1 = lsmt_pkg::MODE_OAM;
				end
			end
		end else begin
			dot_n = dot_inc;
			m1    = lsmt_pkg::MODE_VBLANK;
			if (dot_inc >= DotsLine) begin
				dot_n = dot_inc - DotsLine;
				l2_en = 1'b1;
				if (line_q == LastLine) begin
					// frame wrap
					m2_en   = 1'b1;
					rst_p   = 1'b1;
					l2_line = 8'd0;
				end else begin
					l2_line = line_inc;
				end
				line_n = l2_line;
			end
		end
	end

	// Apply the steps in order to the STAT tracking
	always_comb begin
		trk0 = '{mode: mode_q, coinc: coinc_q, prev: prev_q,
		         stat_p: 1'b0, oam_p: 1'b0, xfer_p: 1'b0};
		trk1 = l1_en ? lsmt_pkg::apply_line(trk0, item.compare_line == line_inc,
		                                    item.stat_enables) : trk0;
		trk2 = lsmt_pkg::apply_mode(trk1, m1, item.stat_enables);
		trk3 = m2_en ? lsmt_pkg::apply_mode(trk2, lsmt_pkg::MODE_OAM, item.stat_enables)
		             : trk2;
		trk4 = l2_en ? lsmt_pkg::apply_line(trk3, item.compare_line == l2_line,
		                                    item.stat_enables) : trk3;
	end

	// Result of this tick
	always_comb begin
		res.line                 = line_n;
		res.mode                 = trk4.mode;
		res.coincidence          = trk4.coinc;
		res.stat_request         = trk4.stat_p;
		res.vblank_request       = vbl_p;
		res.oam_search_start     = trk4.oam_p;
		res.pixel_transfer_start = trk4.xfer_p;
		res.frame_restart        = rst_p;
	end

	// Timing state, updated as a beat moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q   <= 9'd0;
			line_q  <= 8'd0;
			mode_q  <= lsmt_pkg::MODE_HBLANK;
			prev_q  <= 1'b0;
			coinc_q <= 1'b0;
		end else if (advance) begin
			dot_q   <= dot_n;
			line_q  <= line_n;
			mode_q  <= trk4.mode;
			prev_q  <= trk4.prev;
			coinc_q <= trk4.coinc;
		end
	end

	`ASSERT_PROP(a_dot_in_line, clk, arst_n, dot_q < DotsLine, "dot counter past line length")
	`ASSERT_PROP(a_off_clears, clk, arst_n, advance && !item.lcd_enable |=> (dot_q == 9'd0 && line_q == 8'd0 && mode_q == lsmt_pkg::MODE_HBLANK), "LCD off did not clear timing")
	`ASSERT_PROP(a_hold_on_stall, clk, arst_n, !advance |=> ($stable(dot_q) && $stable(line_q) && $stable(mode_q) && $stable(prev_q)), "timing state moved without a beat")
	`ASSERT_NEVER(a_restart_mode, clk, arst_n, advance && rst_p && (line_n != 8'd0 || trk4.mode != lsmt_pkg::MODE_OAM), "frame wrap not at line 0 in OAM search")

endmodule
